/* sv/rtufr_pkg.sv */
// ----------------------------------------------------------------------------
// rtufr_pkg
// Shared codes, constants and the CRC-16/MODBUS byte fold used by the RTU
// frame receiver.
// ----------------------------------------------------------------------------
package rtufr_pkg;

  // Input word kinds, carried on in_tuser.
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Result status codes, carried on out_tuser.
  localparam logic [1:0] ST_READY    = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_SHORT    = 2'd2;
  localparam logic [1:0] ST_READ     = 2'd3;

  // CRC-16/MODBUS constants.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Reset value of the frame delay register, in ticks.
  localparam logic [15:0] FRAME_DELAY_RESET = 16'd1750;

  // Largest silence count; the counter saturates here.
  localparam logic [15:0] SILENCE_MAX = 16'hFFFF;

  typedef logic [15:0] crc_t;

  // Fold one byte into the running CRC, one polynomial step per bit.
  function automatic crc_t crc_fold(input crc_t crc_in, input logic [7:0] data);
    crc_t c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* sv/rtu_frame_receiver_unit.sv */
// ----------------------------------------------------------------------------
// rtu_frame_receiver_unit
// Modbus RTU receive framer: stores frame bytes, tracks the CRC, closes
// frames on inter-byte silence and serves reads of the stored frame.
// ----------------------------------------------------------------------------
// The block takes one input word in every cycle, of any kind, as long as the
// result side keeps up. A word that gives a result (a frame close on a tick,
// or a read) passes to the middle stage, which waits on the registered read
// port of the frame store, and then to the output register, which shows it.
// Bytes and ticks that give no result only update state.
// The frame store has no reset; a new frame overwrites it from position
// zero, and reads at or beyond the current frame length return zero.
module rtu_frame_receiver_unit
  import rtufr_pkg::*;
#(
  parameter int BUFFER_BYTES = 256,
  parameter int HEADER_BYTES = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input words.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] rx_byte, [15:8] read_index
  input  logic [1:0]  in_tuser,   // [1:0] kind
  // Result words.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [8:0] frame_length, [9] crc_ok,
                                  // [17:10] read_data, [23:18] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  // Frame delay register write.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // [15:0] frame delay in ticks
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);

  // Configuration register.
  logic [15:0] frame_delay_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_delay_r <= FRAME_DELAY_RESET;
    end else if (cfg_valid) begin
      frame_delay_r <= cfg_data;
    end
  end

  // Frame state.
  logic          receiving_r, receiving_nxt;
  logic [CW-1:0] byte_count_r, byte_count_nxt;
  logic          overflowed_r, overflowed_nxt;
  logic [15:0]   silence_r, silence_nxt;
  crc_t          crc_r, crc_nxt;

  // Frame store.
  logic [7:0]    store_mem [BUFFER_BYTES];
  logic [7:0]    store_q_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  // Middle stage, waiting on the store read data.
  logic        mid_vld_r, mid_vld_nxt;
  logic [1:0]  mid_status_r, mid_status_nxt;
  logic [8:0]  mid_len_r, mid_len_nxt;
  logic        mid_ok_r, mid_ok_nxt;
  logic        mid_hit_r, mid_hit_nxt;

  // Output register.
  logic        out_vld_r;
  logic [1:0]  out_status_r;
  logic [8:0]  out_len_r;
  logic        out_ok_r;
  logic [7:0]  out_data_r;

  logic        in_acc;
  logic        mid_adv;
  logic [1:0]  in_kind;
  logic [7:0]  in_rx;
  logic [7:0]  in_idx;
  logic [31:0] idx_ext;
  logic [31:0] cnt_ext;
  logic [CW-1:0] cnt_base;
  crc_t        crc_base;
  logic [15:0] silence_inc;
  logic        has_result;

  assign in_kind = in_tuser;
  assign in_rx   = in_tdata[7:0];
  assign in_idx  = in_tdata[15:8];
  assign idx_ext = {24'd0, in_idx};
  assign cnt_ext = 32'(byte_count_r);

  // The middle stage moves on when the output register is free or drained.
  assign mid_adv   = mid_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !mid_vld_r || !out_vld_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // A byte opens a new frame when none is open.
  assign cnt_base    = receiving_r ? byte_count_r : '0;
  assign crc_base    = receiving_r ? crc_r : CRC_INIT;
  assign silence_inc = (silence_r == SILENCE_MAX) ? silence_r : silence_r + 16'd1;

  // Next state, store access and the result of the accepted word.
  always_comb begin
    receiving_nxt  = receiving_r;
    byte_count_nxt = byte_count_r;
    overflowed_nxt = overflowed_r;
    silence_nxt    = silence_r;
    crc_nxt        = crc_r;
    mem_we         = 1'b0;
    mem_waddr      = cnt_base[AW-1:0];
    mem_re         = 1'b0;
    mem_raddr      = idx_ext[AW-1:0];
    has_result     = 1'b0;
    mid_status_nxt = ST_READ;
    mid_len_nxt    = 9'd0;
    mid_ok_nxt     = 1'b0;
    mid_hit_nxt    = 1'b0;
    if (in_acc) begin
      unique case (in_kind)
        KIND_BYTE: begin
          receiving_nxt = 1'b1;
          if (32'(cnt_base) < 32'(BUFFER_BYTES)) begin
            mem_we         = 1'b1;
            byte_count_nxt = cnt_base + CW'(1);
          end else begin
            byte_count_nxt = cnt_base;
            overflowed_nxt = 1'b1;
          end
          crc_nxt     = crc_fold(crc_base, in_rx);
          silence_nxt = 16'd0;
        end
        KIND_TICK: begin
          if (receiving_r) begin
            silence_nxt = silence_inc;
            if (silence_inc >= frame_delay_r) begin
              receiving_nxt = 1'b0;
              silence_nxt   = 16'd0;
              has_result    = 1'b1;
              mid_len_nxt   = cnt_ext[8:0];
              priority if (overflowed_r) begin
                overflowed_nxt = 1'b0;
                mid_status_nxt = ST_OVERFLOW;
              end else if (cnt_ext < 32'(HEADER_BYTES + 2)) begin
                mid_status_nxt = ST_SHORT;
              end else begin
                mid_status_nxt = ST_READY;
                mid_ok_nxt     = (crc_r == 16'd0);
              end
            end
          end
        end
        KIND_READ: begin
          has_result     = 1'b1;
          mem_re         = 1'b1;
          mid_status_nxt = ST_READ;
          mid_hit_nxt    = (idx_ext < cnt_ext) && (idx_ext < 32'(BUFFER_BYTES));
        end
        default: begin
          // Unused kind: no effect.
        end
      endcase
    end
    mid_vld_nxt = (in_acc && has_result) || (mid_vld_r && !mid_adv);
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r  <= 1'b0;
      byte_count_r <= '0;
      overflowed_r <= 1'b0;
      silence_r    <= 16'd0;
      crc_r        <= CRC_INIT;
    end else begin
      receiving_r  <= receiving_nxt;
      byte_count_r <= byte_count_nxt;
      overflowed_r <= overflowed_nxt;
      silence_r    <= silence_nxt;
      crc_r        <= crc_nxt;
    end
  end

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= in_rx;
    end
    if (mem_re) begin
      store_q_r <= store_mem[mem_raddr];
    end
  end

  // Middle stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_vld_r <= 1'b0;
    end else begin
      mid_vld_r <= mid_vld_nxt;
    end
    if (in_acc && has_result) begin
      mid_status_r <= mid_status_nxt;
      mid_len_r    <= mid_len_nxt;
      mid_ok_r     <= mid_ok_nxt;
      mid_hit_r    <= mid_hit_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (mid_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
    if (mid_adv) begin
      out_status_r <= mid_status_r;
      out_len_r    <= mid_len_r;
      out_ok_r     <= mid_ok_r;
      out_data_r   <= ((mid_status_r == ST_READ) && mid_hit_r) ? store_q_r : 8'd0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'd0, out_data_r, out_ok_r, out_len_r};

endmodule
